// ----- rtl/core/rrtb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rrtb_pkg;

  localparam int COORD_BITS_DEF     = 12;
  localparam int DIST_FRAC_BITS_DEF = 4;

  localparam int SIZE_BITS      = 12;
  localparam int RADIUS_BITS    = 11;
  localparam int COLOR_BITS     = 32;
  localparam int CHAN_CNT_BITS  = 3;
  localparam int REG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  // Root digits resolved per pipeline stage
  localparam int SQRT_STEPS = 2;

  localparam int FALLOFF_LEN  = 42;
  localparam int TAB_IDX_BITS = 6;

  localparam logic [7:0] BYTE_MAX = 8'hFF;

  localparam logic [CHAN_CNT_BITS-1:0] CHAN_RGB  = 3'd3;
  localparam logic [CHAN_CNT_BITS-1:0] CHAN_RGBA = 3'd4;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_WIDGET_WIDTH   = 3'd0,
    REG_WIDGET_HEIGHT  = 3'd1,
    REG_CORNER_RADIUS  = 3'd2,
    REG_FORE_COLOR     = 3'd3,
    REG_BACK_COLOR     = 3'd4,
    REG_IMAGE_CHANNELS = 3'd5
  } reg_index_t;

  localparam logic [SIZE_BITS-1:0]     WIDTH_RST    = 12'd64;
  localparam logic [SIZE_BITS-1:0]     HEIGHT_RST   = 12'd32;
  localparam logic [RADIUS_BITS-1:0]   RADIUS_RST   = 11'd0;
  localparam logic [COLOR_BITS-1:0]    FORE_RST     = 32'hFFFF_FFFF;
  localparam logic [COLOR_BITS-1:0]    BACK_RST     = 32'hFFD5_740D;
  localparam logic [CHAN_CNT_BITS-1:0] CHANNELS_RST = 3'd0;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  text_coverage;
    logic [7:0]  texel_zero;
    logic [7:0]  texel_one;
    logic [7:0]  texel_two;
    logic [7:0]  texel_three;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_chan0;
    logic [7:0] out_chan1;
    logic [7:0] out_chan2;
    logic [7:0] out_alpha;
  } pix_out_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0]     widget_width;
    logic [SIZE_BITS-1:0]     widget_height;
    logic [RADIUS_BITS-1:0]   corner_radius;
    logic [COLOR_BITS-1:0]    fore_color;
    logic [COLOR_BITS-1:0]    back_color;
    logic [CHAN_CNT_BITS-1:0] image_channels;
  } cfg_t;

  // Falloff alpha in 1/16 pixel steps; entries past the table read zero
  localparam logic [7:0] FALLOFF_TAB [0:63] = '{
    8'd254, 8'd227, 8'd202, 8'd179, 8'd160, 8'd142, 8'd126, 8'd113,
    8'd100, 8'd89,  8'd79,  8'd70,  8'd62,  8'd56,  8'd49,  8'd44,
    8'd39,  8'd34,  8'd30,  8'd27,  8'd24,  8'd21,  8'd19,  8'd16,
    8'd14,  8'd13,  8'd11,  8'd10,  8'd9,   8'd7,   8'd6,   8'd6,
    8'd5,   8'd4,   8'd4,   8'd3,   8'd2,   8'd2,   8'd2,   8'd1,
    8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
  };

  // Edge distance width: covers radius + coordinate + 1 for any size
  function automatic int dx_bits(input int coord_bits);
    return ((coord_bits > SIZE_BITS) ? coord_bits : SIZE_BITS) + 1;
  endfunction

  // Radicand width: squared distance sum, fraction bits, padded to even
  function automatic int rad_bits(input int coord_bits, input int frac_bits);
    return 2 * dx_bits(coord_bits) + 2 + 2 * frac_bits;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rrtb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rrtb_front import rrtb_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEF,
  localparam int DX_BITS  = dx_bits(COORD_BITS),
  localparam int SQ_BITS  = 2 * DX_BITS + 1,
  localparam int RAD_BITS = rad_bits(COORD_BITS, DIST_FRAC_BITS)
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  input  pix_in_t             pixel,
  output logic                rad_valid,
  input  logic                rad_stall,
  output logic [RAD_BITS-1:0] rad,
  output pix_out_t            color
);

  function automatic logic [DX_BITS-1:0] edge_dist(
    input logic [COORD_BITS-1:0]  p,
    input logic [SIZE_BITS-1:0]   size,
    input logic [RADIUS_BITS-1:0] r
  );
    logic [DX_BITS-1:0] pe;
    logic [DX_BITS-1:0] se;
    logic [DX_BITS-1:0] re;
    pe = DX_BITS'(p);
    se = DX_BITS'(size);
    re = DX_BITS'(r);
    if (pe < re) begin
      return re - pe;
    end else if (pe + re >= se) begin
      return pe + re - se + DX_BITS'(1);
    end
    return '0;
  endfunction

  logic ld1, ld2, ld3;
  logic v1, v2, v3;

  // Stage 1: edge distances and texel tint
  logic [7:0]         tsel [4];
  logic [15:0]        tint_c [4];
  logic [DX_BITS-1:0] dx1, dy1;
  logic [7:0]         cov1;
  logic [15:0]        tint1 [4];

  // Stage 2: squares and blend products
  logic [7:0]           back_c [4];
  logic [7:0]           ncov;
  logic [2*DX_BITS-1:0] sqx2, sqy2;
  logic [15:0]          fprod2 [4];
  logic [15:0]          bprod2 [4];

  // Stage 3: squared distance sum and blended bytes
  logic [15:0]        bsum [4];
  logic [SQ_BITS-1:0] sq3;
  pix_out_t           col3;

  assign ld3 = !v3 || !rad_stall;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;
  assign pixel_stall = !ld1;

  always_comb begin
    tsel[0] = pixel.texel_zero;
    tsel[1] = (cfg.image_channels >= CHAN_RGB) ? pixel.texel_one : pixel.texel_zero;
    tsel[2] = (cfg.image_channels >= CHAN_RGB) ? pixel.texel_two : pixel.texel_zero;
    tsel[3] = (cfg.image_channels >= CHAN_RGBA) ? pixel.texel_three : BYTE_MAX;
    for (int k = 0; k < 4; k++) begin
      tint_c[k] = 16'(cfg.back_color[8*k +: 8]) * 16'(tsel[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ld1) begin
      v1 <= pixel_valid;
    end
    if (ld1) begin
      dx1  <= edge_dist(COORD_BITS'(pixel.pixel_x), cfg.widget_width, cfg.corner_radius);
      dy1  <= edge_dist(COORD_BITS'(pixel.pixel_y), cfg.widget_height, cfg.corner_radius);
      cov1 <= pixel.text_coverage;
      for (int k = 0; k < 4; k++) begin
        tint1[k] <= tint_c[k];
      end
    end
  end

  always_comb begin
    ncov = BYTE_MAX - cov1;
    for (int k = 0; k < 4; k++) begin
      back_c[k] = (cfg.image_channels != '0) ? tint1[k][15:8] : cfg.back_color[8*k +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ld2) begin
      v2 <= v1;
    end
    if (ld2) begin
      sqx2 <= (2*DX_BITS)'(dx1) * (2*DX_BITS)'(dx1);
      sqy2 <= (2*DX_BITS)'(dy1) * (2*DX_BITS)'(dy1);
      for (int k = 0; k < 4; k++) begin
        fprod2[k] <= 16'(cov1) * 16'(cfg.fore_color[8*k +: 8]);
        bprod2[k] <= 16'(ncov) * 16'(back_c[k]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      bsum[k] = fprod2[k] + bprod2[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ld3) begin
      v3 <= v2;
    end
    if (ld3) begin
      sq3            <= SQ_BITS'(sqx2) + SQ_BITS'(sqy2);
      col3.out_chan0 <= bsum[0][15:8];
      col3.out_chan1 <= bsum[1][15:8];
      col3.out_chan2 <= bsum[2][15:8];
      col3.out_alpha <= bsum[3][15:8];
    end
  end

  assign rad_valid = v3;
  assign rad       = {1'b0, sq3, {(2*DIST_FRAC_BITS){1'b0}}};
  assign color     = col3;

endmodule

`default_nettype wire

// ----- rtl/core/rrtb_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rrtb_isqrt import rrtb_pkg::*; #(
  parameter int RAD_BITS  = 36,
  parameter int SIDE_BITS = 32,
  localparam int ROOT_BITS = RAD_BITS / 2,
  localparam int REM_BITS  = ROOT_BITS + 2,
  localparam int NSTG      = (ROOT_BITS + SQRT_STEPS - 1) / SQRT_STEPS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rad_valid,
  output logic                 rad_stall,
  input  logic [RAD_BITS-1:0]  rad,
  input  logic [SIDE_BITS-1:0] side_in,
  output logic                 root_valid,
  input  logic                 root_stall,
  output logic [ROOT_BITS-1:0] root,
  output logic [SIDE_BITS-1:0] side_out
);

  logic                 vld    [NSTG+1];
  logic                 ld     [1:NSTG];
  logic [RAD_BITS-1:0]  rad_q  [NSTG];
  logic [REM_BITS-1:0]  rem_q  [NSTG];
  logic [ROOT_BITS-1:0] root_q [NSTG+1];
  logic [SIDE_BITS-1:0] side_q [NSTG+1];

  assign vld[0]    = rad_valid;
  assign rad_q[0]  = rad;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = side_in;

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [RAD_BITS-1:0]  rad_c;
    logic [REM_BITS-1:0]  rem_c;
    logic [ROOT_BITS-1:0] root_c;
    logic [REM_BITS-1:0]  rem_sh;
    logic [REM_BITS-1:0]  trial;

    if (s == NSTG - 1) begin : g_last
      assign ld[s+1] = !vld[s+1] || !root_stall;
    end else begin : g_mid
      assign ld[s+1] = !vld[s+1] || ld[s+2];
    end

    // Restoring root digits: bring down two radicand bits, try 4*root+1
    always_comb begin
      rad_c  = rad_q[s];
      rem_c  = rem_q[s];
      root_c = root_q[s];
      rem_sh = '0;
      trial  = '0;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        if (s * SQRT_STEPS + j < ROOT_BITS) begin
          rem_sh = {rem_c[REM_BITS-3:0], rad_c[RAD_BITS-1 -: 2]};
          trial  = {root_c, 2'b01};
          if (rem_sh >= trial) begin
            rem_c  = rem_sh - trial;
            root_c = {root_c[ROOT_BITS-2:0], 1'b1};
          end else begin
            rem_c  = rem_sh;
            root_c = {root_c[ROOT_BITS-2:0], 1'b0};
          end
          rad_c = {rad_c[RAD_BITS-3:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (ld[s+1]) begin
        vld[s+1] <= vld[s];
      end
      if (ld[s+1]) begin
        root_q[s+1] <= root_c;
        side_q[s+1] <= side_q[s];
      end
    end

    if (s < NSTG - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ld[s+1]) begin
          rad_q[s+1] <= rad_c;
          rem_q[s+1] <= rem_c;
        end
      end
    end
  end

  assign rad_stall  = !ld[1];
  assign root_valid = vld[NSTG];
  assign root       = root_q[NSTG];
  assign side_out   = side_q[NSTG];

endmodule

`default_nettype wire

// ----- rtl/core/rrtb_falloff.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rrtb_falloff import rrtb_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEF,
  localparam int ROOT_BITS = rad_bits(COORD_BITS, DIST_FRAC_BITS) / 2,
  localparam int IDX_BITS  = ROOT_BITS + 4,
  localparam int SHR       = (DIST_FRAC_BITS >= 4) ? DIST_FRAC_BITS - 4 : 0,
  localparam int SHL       = (DIST_FRAC_BITS < 4) ? 4 - DIST_FRAC_BITS : 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 root_valid,
  output logic                 root_stall,
  input  logic [ROOT_BITS-1:0] root,
  input  pix_out_t             color,
  output logic                 result_valid,
  input  logic                 result_stall,
  output pix_out_t             result
);

  logic ld1, ld2;
  logic v1, v2;

  logic [ROOT_BITS-1:0]    r_fix;
  logic [ROOT_BITS-1:0]    diff;
  logic [IDX_BITS-1:0]     idx_full;
  logic                    repl_c;
  logic [TAB_IDX_BITS-1:0] idx_c;

  logic                    repl1;
  logic [TAB_IDX_BITS-1:0] idx1;
  pix_out_t                col1;
  pix_out_t                res2;

  assign ld2 = !v2 || !result_stall;
  assign ld1 = !v1 || ld2;
  assign root_stall = !ld1;

  // Distance past the radius, rescaled to sixteenths of a pixel
  always_comb begin
    r_fix    = ROOT_BITS'({cfg.corner_radius, {DIST_FRAC_BITS{1'b0}}});
    diff     = root - r_fix;
    idx_full = (IDX_BITS'(diff) >> SHR) << SHL;
    repl_c   = (cfg.corner_radius != '0) && (root > r_fix);
    idx_c    = (idx_full < IDX_BITS'(FALLOFF_LEN)) ? idx_full[TAB_IDX_BITS-1:0]
                                                   : TAB_IDX_BITS'(FALLOFF_LEN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ld1) begin
      v1 <= root_valid;
    end
    if (ld1) begin
      repl1 <= repl_c;
      idx1  <= idx_c;
      col1  <= color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ld2) begin
      v2 <= v1;
    end
    if (ld2) begin
      res2.out_chan0 <= col1.out_chan0;
      res2.out_chan1 <= col1.out_chan1;
      res2.out_chan2 <= col1.out_chan2;
      res2.out_alpha <= repl1 ? FALLOFF_TAB[idx1] : col1.out_alpha;
    end
  end

  assign result_valid = v2;
  assign result       = res2;

endmodule

`default_nettype wire

// ----- rtl/core/rounded_rect_text_blend.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Rounded rectangle text blend: one pixel word per clock in, one per clock out while
// no stall holds them, in order. Each word is tinted by the optional image texel, blended
// with the text coverage against the foreground color, and, where it lies past a rounded
// corner (nonzero corner radius), gets the corner falloff alpha. The root has R bits,
// R = DX + 1 + DIST_FRAC_BITS, where DX = max(COORD_BITS, 12) + 1; the integer square root
// resolves two root digits per stage and so sets the depth. Stall on the result side fills
// bubbles before it holds the input. Register writes are taken at any time (cfg_ready is
// always high) but must only be made while no pixel is in flight.

module rounded_rect_text_blend import rrtb_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pixel_valid,
  output logic                      pixel_stall,
  input  pix_in_t                   pixel,
  output logic                      result_valid,
  input  logic                      result_stall,
  output pix_out_t                  result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [REG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int RAD_BITS  = rad_bits(COORD_BITS, DIST_FRAC_BITS);
  localparam int ROOT_BITS = RAD_BITS / 2;

  cfg_t cfg;

  logic                 rad_valid, rad_stall;
  logic [RAD_BITS-1:0]  rad;
  pix_out_t             color;
  logic                 root_valid, root_stall;
  logic [ROOT_BITS-1:0] root;
  logic [$bits(pix_out_t)-1:0] side_root;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.widget_width   <= WIDTH_RST;
      cfg.widget_height  <= HEIGHT_RST;
      cfg.corner_radius  <= RADIUS_RST;
      cfg.fore_color     <= FORE_RST;
      cfg.back_color     <= BACK_RST;
      cfg.image_channels <= CHANNELS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDGET_WIDTH:   cfg.widget_width   <= cfg_data[SIZE_BITS-1:0];
        REG_WIDGET_HEIGHT:  cfg.widget_height  <= cfg_data[SIZE_BITS-1:0];
        REG_CORNER_RADIUS:  cfg.corner_radius  <= cfg_data[RADIUS_BITS-1:0];
        REG_FORE_COLOR:     cfg.fore_color     <= cfg_data[COLOR_BITS-1:0];
        REG_BACK_COLOR:     cfg.back_color     <= cfg_data[COLOR_BITS-1:0];
        REG_IMAGE_CHANNELS: cfg.image_channels <= cfg_data[CHAN_CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  rrtb_front #(
    .COORD_BITS     (COORD_BITS),
    .DIST_FRAC_BITS (DIST_FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .rad_valid   (rad_valid),
    .rad_stall   (rad_stall),
    .rad         (rad),
    .color       (color)
  );

  rrtb_isqrt #(
    .RAD_BITS  (RAD_BITS),
    .SIDE_BITS ($bits(pix_out_t))
  ) u_isqrt (
    .clk        (clk),
    .rst        (rst),
    .rad_valid  (rad_valid),
    .rad_stall  (rad_stall),
    .rad        (rad),
    .side_in    (color),
    .root_valid (root_valid),
    .root_stall (root_stall),
    .root       (root),
    .side_out   (side_root)
  );

  rrtb_falloff #(
    .COORD_BITS     (COORD_BITS),
    .DIST_FRAC_BITS (DIST_FRAC_BITS)
  ) u_falloff (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .root_valid   (root_valid),
    .root_stall   (root_stall),
    .root         (root),
    .color        (pix_out_t'(side_root)),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// ----- rtl/core/rrtb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rrtb_checker import rrtb_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     pixel_valid,
  input logic     pixel_stall,
  input logic     result_valid,
  input logic     result_stall,
  input pix_out_t result,
  input logic     cfg_valid,
  input logic     cfg_ready
);

  // Hold a stalled result word
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed or vanished");

  // Drop all words in flight on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // An empty or draining output register never pushes back on the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!result_valid || !result_stall) |-> !pixel_stall)
    else $error("input stalled while the output side can advance");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write not taken");

endmodule

bind rounded_rect_text_blend rrtb_checker u_rrtb_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import rrtb_pkg::*;

  localparam int LIMIT_CYCLES    = 200000;
  localparam int HOLD_CYCLES     = 400;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 105;
  localparam int DRAIN_CYCLES    = 40;
  localparam int FRAC            = DIST_FRAC_BITS_DEF;
  localparam int FALLOFF_STEPS   = 42;

  // Unmapped register indexes: writes there must be dropped
  localparam logic [REG_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

  localparam logic [7:0] ALPHA_FALLOFF [FALLOFF_STEPS] = '{
    8'd254, 8'd227, 8'd202, 8'd179, 8'd160, 8'd142, 8'd126, 8'd113, 8'd100, 8'd89,
    8'd79,  8'd70,  8'd62,  8'd56,  8'd49,  8'd44,  8'd39,  8'd34,  8'd30,  8'd27,
    8'd24,  8'd21,  8'd19,  8'd16,  8'd14,  8'd13,  8'd11,  8'd10,  8'd9,   8'd7,
    8'd6,   8'd6,   8'd5,   8'd4,   8'd4,   8'd3,   8'd2,   8'd2,   8'd2,   8'd1,
    8'd1,   8'd1
  };

  // Plain background at power-up colors, zero coverage, with and without corner cut
  localparam pix_out_t BG_PLAIN  = '{8'd12, 8'd115, 8'd212, 8'd254};
  localparam pix_out_t BG_CORNER = '{8'd12, 8'd115, 8'd212, 8'd0};

  typedef longint unsigned u64_t;

  typedef enum logic {ROW_REG, ROW_PIX} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [REG_INDEX_BITS-1:0] idx;
    logic [31:0]               data;
    pix_in_t                   px;
    bit                        typed;
    pix_out_t                  want;
  } stim_row_t;

  logic                      clk;
  logic                      rst;
  logic                      pixel_valid;
  logic                      pixel_stall;
  pix_in_t                   pixel;
  logic                      result_valid;
  logic                      result_stall;
  pix_out_t                  result;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [REG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  cfg_t      shadow;
  pix_out_t  blend_queue [$];
  stim_row_t directed_rows [$];
  int        fail_count    = 0;
  int        words_checked = 0;
  int        falloff_words = 0;
  int        writes_done   = 0;
  int        cycles        = 0;
  int        send_idle_pct = 28;
  int        recv_idle_pct = 28;
  bit        hold_req      = 1'b0;

  rounded_rect_text_blend DUT (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic u64_t root_floor(input u64_t v);
    u64_t lo;
    u64_t hi;
    u64_t mid;
    lo = 0;
    hi = u64_t'(1) << 20;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint edge_offset(input longint p, input longint size, input longint r);
    if (p < r) return r - p;
    if (p >= size - r) return r + p - size + 1;
    return 0;
  endfunction

  function automatic pix_out_t blend_pixel(input pix_in_t p, input cfg_t c,
                                           output bit falloff_hit);
    logic [7:0] mix [4];
    int         tex [4];
    int         cov;
    int         fore_k;
    int         back_k;
    longint     r;
    longint     dx;
    longint     dy;
    longint     s;
    longint     d;
    longint     idx;
    cov = p.text_coverage;
    tex[0] = p.texel_zero;
    tex[1] = (c.image_channels >= CHAN_RGB) ? p.texel_one : p.texel_zero;
    tex[2] = (c.image_channels >= CHAN_RGB) ? p.texel_two : p.texel_zero;
    tex[3] = (c.image_channels >= CHAN_RGBA) ? p.texel_three : 255;
    falloff_hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      fore_k = c.fore_color[8*k +: 8];
      back_k = c.back_color[8*k +: 8];
      // tint the texel by the back color
      if (c.image_channels != 0) back_k = (back_k * tex[k]) >> 8;
      mix[k] = 8'((cov * fore_k + (255 - cov) * back_k) >> 8);
    end
    if (c.corner_radius != 0) begin
      r  = c.corner_radius;
      dx = edge_offset(p.pixel_x, c.widget_width, r);
      dy = edge_offset(p.pixel_y, c.widget_height, r);
      s  = longint'(root_floor(u64_t'(dx * dx + dy * dy) << (2 * FRAC)));
      d  = s - (r << FRAC);
      if (d > 0) begin
        // rescale to sixteenths of a pixel
        idx = (FRAC >= 4) ? (d >> ((FRAC >= 4) ? FRAC - 4 : 0))
                          : (d << ((FRAC < 4) ? 4 - FRAC : 0));
        mix[3] = (idx < FALLOFF_STEPS) ? ALPHA_FALLOFF[idx] : 8'd0;
        falloff_hit = 1'b1;
      end
    end
    return '{mix[0], mix[1], mix[2], mix[3]};
  endfunction

  function automatic stim_row_t px_row(input logic [11:0] x, input logic [11:0] y,
                                       input logic [7:0] cov, input logic [31:0] tex,
                                       input bit typed = 1'b0, input pix_out_t want = '0);
    stim_row_t row;
    row.kind  = ROW_PIX;
    row.idx   = '0;
    row.data  = '0;
    row.px    = '{x, y, cov, tex[31:24], tex[23:16], tex[15:8], tex[7:0]};
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [REG_INDEX_BITS-1:0] idx,
                                        input logic [31:0] data);
    stim_row_t row;
    row.kind  = ROW_REG;
    row.idx   = idx;
    row.data  = data;
    row.px    = '0;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic logic [11:0] near_coord(input int size, input int r);
    int off;
    off = $urandom_range(r + 3);
    if ($urandom_range(1) == 0) return 12'(off);
    return 12'(size - 1 - off);
  endfunction

  function automatic pix_in_t rand_pixel();
    pix_in_t     p;
    logic [31:0] tex;
    tex = $urandom();
    if ($urandom_range(9) < 3) begin
      p.pixel_x = 12'($urandom_range(4095));
      p.pixel_y = 12'($urandom_range(4095));
    end else begin
      // aim at the corner band where the falloff lives
      p.pixel_x = near_coord(int'(shadow.widget_width), int'(shadow.corner_radius));
      p.pixel_y = near_coord(int'(shadow.widget_height), int'(shadow.corner_radius));
    end
    case ($urandom_range(5))
      0: p.text_coverage = 8'd0;
      1: p.text_coverage = 8'd255;
      default: p.text_coverage = 8'($urandom_range(255));
    endcase
    p.texel_zero  = tex[31:24];
    p.texel_one   = tex[23:16];
    p.texel_two   = tex[15:8];
    p.texel_three = tex[7:0];
    return p;
  endfunction

  function automatic logic [11:0] pick_size();
    case ($urandom_range(9))
      0: return 12'd1;
      1: return 12'd4095;
      2: return 12'd0;
      3, 4: return 12'($urandom_range(1, 4095));
      default: return 12'($urandom_range(2, 200));
    endcase
  endfunction

  function automatic logic [31:0] pick_color();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_pixel(input pix_in_t p, input bit typed, input pix_out_t want);
    pix_out_t guess;
    bit       hit;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (pixel_stall);
    guess = blend_pixel(p, shadow, hit);
    if (hit) falloff_words++;
    blend_queue.push_back(typed ? want : guess);
  endtask

  task automatic drain();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (blend_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_INDEX_BITS-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDGET_WIDTH:   shadow.widget_width   = data[SIZE_BITS-1:0];
      REG_WIDGET_HEIGHT:  shadow.widget_height  = data[SIZE_BITS-1:0];
      REG_CORNER_RADIUS:  shadow.corner_radius  = data[RADIUS_BITS-1:0];
      REG_FORE_COLOR:     shadow.fore_color     = data;
      REG_BACK_COLOR:     shadow.back_color     = data;
      REG_IMAGE_CHANNELS: shadow.image_channels = data[CHAN_CNT_BITS-1:0];
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_random_setting(input int phase);
    logic [31:0] junk;
    logic [11:0] w;
    logic [11:0] h;
    logic [10:0] r;
    w = pick_size();
    h = pick_size();
    case ($urandom_range(9))
      0: r = 11'd0;
      1: r = 11'd2047;
      2: r = 11'($urandom_range(2047));
      default: r = 11'($urandom_range(1, 40));
    endcase
    if (phase == 0) begin
      w = 12'd4095;
      h = 12'd4095;
      r = 11'd2047;
    end else if (phase == 1) begin
      w = 12'd1;
      h = 12'd1;
      r = 11'd1;
    end
    // fill the unused upper bits with junk; the block must mask them
    junk = $urandom();
    write_reg(REG_WIDGET_WIDTH, {junk[31:12], w});
    junk = $urandom();
    write_reg(REG_WIDGET_HEIGHT, {junk[31:12], h});
    junk = $urandom();
    write_reg(REG_CORNER_RADIUS, {junk[31:11], r});
    write_reg(REG_FORE_COLOR, pick_color());
    write_reg(REG_BACK_COLOR, pick_color());
    junk = $urandom();
    write_reg(REG_IMAGE_CHANNELS, {junk[31:3], 3'($urandom_range(7))});
    if ($urandom_range(3) == 0) begin
      write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    pix_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (blend_queue.size() == 0) begin
        $error("result word %h arrived with nothing expected", result);
        fail_count++;
      end else begin
        want = blend_queue.pop_front();
        words_checked++;
        check_field("out_chan0", want.out_chan0, result.out_chan0);
        check_field("out_chan1", want.out_chan1, result.out_chan1);
        check_field("out_chan2", want.out_chan2, result.out_chan2);
        check_field("out_alpha", want.out_alpha, result.out_alpha);
      end
    end
  end

  initial begin : result_side
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // hold the output side so the pipe backs up into the input
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    rst         = 1'b1;
    pixel_valid = 1'b0;
    pixel       = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    shadow      = '{widget_width: 12'd64, widget_height: 12'd32, corner_radius: 11'd0,
                    fore_color: 32'hFFFF_FFFF, back_color: 32'hFFD5_740D,
                    image_channels: 3'd0};

    // power-up colors, extremes of position and coverage
    directed_rows.push_back(px_row(12'd0, 12'd0, 8'd0, 32'h0000_0000, 1'b1, BG_PLAIN));
    directed_rows.push_back(px_row(12'd4095, 12'd4095, 8'd255, 32'hFFFF_FFFF, 1'b1,
                                   pix_out_t'{8'd254, 8'd254, 8'd254, 8'd254}));
    directed_rows.push_back(px_row(12'd10, 12'd5, 8'd128, 32'h1234_5678));
    // grey texel spread to all channels, opaque texel alpha, channel counts past four
    directed_rows.push_back(reg_row(REG_IMAGE_CHANNELS, 32'd1));
    directed_rows.push_back(px_row(12'd3, 12'd3, 8'd0, 32'hFF00_0000));
    directed_rows.push_back(reg_row(REG_IMAGE_CHANNELS, 32'd2));
    directed_rows.push_back(px_row(12'd7, 12'd9, 8'd64, 32'h80C0_20A0));
    directed_rows.push_back(reg_row(REG_IMAGE_CHANNELS, 32'd3));
    directed_rows.push_back(px_row(12'd7, 12'd9, 8'd0, 32'h8040_C000));
    directed_rows.push_back(reg_row(REG_IMAGE_CHANNELS, 32'd4));
    directed_rows.push_back(px_row(12'd1, 12'd2, 8'd0, 32'hFFFF_FF00));
    directed_rows.push_back(reg_row(REG_IMAGE_CHANNELS, 32'd7));
    directed_rows.push_back(px_row(12'd1, 12'd2, 8'd200, 32'h1122_3344));
    directed_rows.push_back(reg_row(REG_IMAGE_CHANNELS, 32'd0));
    // rounded corners on the power-up 64x32 widget
    directed_rows.push_back(reg_row(REG_CORNER_RADIUS, 32'd8));
    directed_rows.push_back(px_row(12'd0, 12'd0, 8'd0, 32'h0, 1'b1, BG_CORNER));
    directed_rows.push_back(px_row(12'd8, 12'd8, 8'd0, 32'h0, 1'b1, BG_PLAIN));
    directed_rows.push_back(px_row(12'd2, 12'd2, 8'd0, 32'h0));
    directed_rows.push_back(px_row(12'd63, 12'd31, 8'd0, 32'h0, 1'b1, BG_CORNER));
    directed_rows.push_back(px_row(12'd2, 12'd16, 8'd90, 32'h0));
    directed_rows.push_back(px_row(12'd4095, 12'd4095, 8'd0, 32'h0, 1'b1, BG_CORNER));
    // radius larger than half the size
    directed_rows.push_back(reg_row(REG_CORNER_RADIUS, 32'd2047));
    directed_rows.push_back(reg_row(REG_WIDGET_WIDTH, 32'd4095));
    directed_rows.push_back(reg_row(REG_WIDGET_HEIGHT, 32'd1));
    directed_rows.push_back(px_row(12'd2047, 12'd0, 8'd17, 32'h0));
    directed_rows.push_back(px_row(12'd0, 12'd0, 8'd255, 32'h0));
    directed_rows.push_back(reg_row(REG_CORNER_RADIUS, 32'd1));
    directed_rows.push_back(reg_row(REG_WIDGET_WIDTH, 32'd1));
    directed_rows.push_back(reg_row(REG_WIDGET_HEIGHT, 32'd4095));
    directed_rows.push_back(px_row(12'd0, 12'd0, 8'd0, 32'h0));
    directed_rows.push_back(px_row(12'd0, 12'd2000, 8'd0, 32'h0));
    // zero-sized widget
    directed_rows.push_back(reg_row(REG_WIDGET_WIDTH, 32'd0));
    directed_rows.push_back(reg_row(REG_WIDGET_HEIGHT, 32'd0));
    directed_rows.push_back(px_row(12'd5, 12'd7, 8'd40, 32'h0));
    // unmapped indexes must leave every register alone
    directed_rows.push_back(reg_row(REG_SPARE_A, 32'hDEAD_BEEF));
    directed_rows.push_back(reg_row(REG_SPARE_B, 32'h0000_0000));
    directed_rows.push_back(px_row(12'd0, 12'd1, 8'd77, 32'h0));
    directed_rows.push_back(reg_row(REG_CORNER_RADIUS, 32'd0));
    directed_rows.push_back(reg_row(REG_FORE_COLOR, 32'h0000_0000));
    directed_rows.push_back(reg_row(REG_BACK_COLOR, 32'h0000_0000));
    directed_rows.push_back(px_row(12'd9, 12'd9, 8'd255, 32'h0, 1'b1, pix_out_t'(32'h0)));
    directed_rows.push_back(reg_row(REG_FORE_COLOR, 32'hFFFF_FFFF));
    directed_rows.push_back(reg_row(REG_BACK_COLOR, 32'hFFFF_FFFF));
    directed_rows.push_back(px_row(12'd9, 12'd9, 8'd0, 32'h0, 1'b1,
                                   pix_out_t'{8'd254, 8'd254, 8'd254, 8'd254}));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        drain();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      set_random_setting(phase);
      send_idle_pct = 28;
      recv_idle_pct = 28;
      if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        hold_req      = 1'b1;
      end
      for (int n = 0; n < WORDS_PER_PHASE; n++) send_pixel(rand_pixel(), 1'b0, '0);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d pixel words after %0d register writes", words_checked, writes_done);
    $display("%0d words fell past a rounded corner; %0d mismatches", falloff_words, fail_count);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
